### rtl/core/nat_address_pool_translator_unit_assert.svh
// Assertion macros shared by the checker files of the NAT pool translator.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef NAT_ADDRESS_POOL_TRANSLATOR_UNIT_ASSERT_SVH
`define NAT_ADDRESS_POOL_TRANSLATOR_UNIT_ASSERT_SVH

// Same-cycle implication
`define NAPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define NAPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/napt_pkg.sv
// Package for the NAT address pool translator: request/response types,
// command, status, register and state codes. No dependencies.
package napt_pkg;

  localparam int POOL_DEPTH_DEF = 256;
  localparam int ADDR_W         = 32;
  localparam int SIZE_W         = 9;
  localparam int CFG_IDX_W      = 1;
  localparam logic [SIZE_W-1:0] COUNT_MAX = 9'd511;

  typedef enum logic [1:0] {
    CMD_IN  = 2'd0,
    CMD_OUT = 2'd1,
    CMD_REL = 2'd2,
    CMD_RSV = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNKNOWN   = 3'd1,
    ST_FULL      = 3'd2,
    ST_RELEASED  = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_BASE = 1'b0,
    CFG_POOL_SIZE = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DISP,
    S_IN_RD,
    S_SCAN,
    S_FIN
  } state_e;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [ADDR_W-1:0] addr;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] new_addr;
    logic [2:0]        status;
  } rsp_t;

  // Compare flags from the shared unit
  typedef struct packed {
    logic match;
    logic free;
  } alu_flags_t;

endpackage

### rtl/core/napt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module napt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/napt_alu.sv
// Shared arithmetic/compare unit: one 32-bit adder (base + slot or key - base)
// and the slot compare against the key. Depends on napt_pkg.
module napt_alu (
  input  napt_pkg::alu_op_e                  op,
  input  logic [napt_pkg::ADDR_W-1:0]        key,
  input  logic [napt_pkg::ADDR_W-1:0]        base,
  input  logic [napt_pkg::ADDR_W-1:0]        slot,
  input  logic [napt_pkg::ADDR_W-1:0]        rd_data,
  output logic [napt_pkg::ADDR_W-1:0]        sum,
  output napt_pkg::alu_flags_t               flags
);

  logic [napt_pkg::ADDR_W-1:0] opa;
  logic [napt_pkg::ADDR_W-1:0] opb;
  logic                        cin;

  // Single adder: subtract is key + ~base + 1
  always_comb begin
    if (op == napt_pkg::ALU_SUB) begin
      opa = key;
      opb = ~base;
      cin = 1'b1;
    end else begin
      opa = base;
      opb = slot;
      cin = 1'b0;
    end
  end

  assign sum = opa + opb + {{(napt_pkg::ADDR_W-1){1'b0}}, cin};

  assign flags.match = (rd_data == key);
  assign flags.free  = (rd_data == '0);

endmodule

### rtl/core/napt_ctrl.sv
// Sequencer of the NAT pool translator: table clearing, lookup and the
// slot-by-slot scan, result register and used count. Depends on napt_pkg.
module napt_ctrl #(
  parameter int POOL_DEPTH = napt_pkg::POOL_DEPTH_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        start,
  output logic                                        busy,
  input  napt_pkg::req_t                              in_req,
  output logic                                        out_valid,
  output napt_pkg::rsp_t                              out_rsp,
  input  logic [napt_pkg::SIZE_W-1:0]                 pool_size,
  // table RAM
  output logic                                        ram_we,
  output logic [((POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1)-1:0] ram_waddr,
  output logic [napt_pkg::ADDR_W-1:0]                 ram_wdata,
  output logic [((POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1)-1:0] ram_raddr,
  input  logic [napt_pkg::ADDR_W-1:0]                 ram_rdata,
  // shared unit
  output napt_pkg::alu_op_e                           alu_op,
  output logic [napt_pkg::ADDR_W-1:0]                 alu_key,
  output logic [napt_pkg::ADDR_W-1:0]                 alu_slot,
  input  logic [napt_pkg::ADDR_W-1:0]                 alu_sum,
  input  napt_pkg::alu_flags_t                        alu_flags
);

  localparam int IDX_W  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CNT_W  = $clog2(POOL_DEPTH + 1);
  localparam int SZ_W   = (CNT_W > napt_pkg::SIZE_W) ? CNT_W : napt_pkg::SIZE_W;
  localparam int ADDR_W = napt_pkg::ADDR_W;
  localparam int USED_W = napt_pkg::SIZE_W;

  napt_pkg::state_e            state_r, state_nxt;
  napt_pkg::cmd_e              cmd_r, cmd_nxt;
  logic [ADDR_W-1:0]           addr_r, addr_nxt;
  logic [SZ_W-1:0]             idx_r, idx_nxt;
  logic [IDX_W-1:0]            cidx_r, cidx_nxt;
  logic                        pend_r, pend_nxt;
  logic                        hfree_r, hfree_nxt;
  logic [IDX_W-1:0]            free_r, free_nxt;
  logic [IDX_W-1:0]            slot_r, slot_nxt;
  logic [napt_pkg::SIZE_W-1:0] used_r, used_nxt;
  logic                        out_valid_r, out_valid_nxt;
  napt_pkg::rsp_t              out_rsp_r, out_rsp_nxt;

  logic [SZ_W-1:0]             psz;
  logic [SZ_W-1:0]             n_eff;
  logic                        issue;

  // Effective slot count: min(pool_size, POOL_DEPTH)
  assign psz   = SZ_W'(pool_size);
  assign n_eff = (psz > SZ_W'(POOL_DEPTH)) ? SZ_W'(POOL_DEPTH) : psz;
  assign issue = (idx_r < n_eff);

  assign busy      = (state_r != napt_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;
  assign alu_key   = addr_r;
  assign alu_slot  = ADDR_W'(slot_r);

  // State and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= napt_pkg::S_CLEAR;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      hfree_r     <= 1'b0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      hfree_r     <= hfree_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    addr_r    <= addr_nxt;
    cidx_r    <= cidx_nxt;
    free_r    <= free_nxt;
    slot_r    <= slot_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  // Next state and outputs
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    addr_nxt      = addr_r;
    idx_nxt       = idx_r;
    cidx_nxt      = cidx_r;
    pend_nxt      = pend_r;
    hfree_nxt     = hfree_r;
    free_nxt      = free_r;
    slot_nxt      = slot_r;
    used_nxt      = used_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = out_rsp_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r[IDX_W-1:0];
    ram_wdata     = '0;
    ram_raddr     = idx_r[IDX_W-1:0];
    alu_op        = napt_pkg::ALU_ADD;

    case (state_r)
      // Zero every table slot after reset
      napt_pkg::S_CLEAR: begin
        ram_we = 1'b1;
        if (idx_r == SZ_W'(POOL_DEPTH - 1)) begin
          idx_nxt   = '0;
          state_nxt = napt_pkg::S_IDLE;
        end else begin
          idx_nxt = idx_r + SZ_W'(1);
        end
      end

      napt_pkg::S_IDLE: begin
        if (start) begin
          cmd_nxt   = napt_pkg::cmd_e'(in_req.cmd);
          addr_nxt  = in_req.addr;
          state_nxt = napt_pkg::S_DISP;
        end
      end

      // Decode the request; the unit computes addr - pool_base here
      napt_pkg::S_DISP: begin
        alu_op    = napt_pkg::ALU_SUB;
        idx_nxt   = '0;
        pend_nxt  = 1'b0;
        hfree_nxt = 1'b0;
        case (cmd_r)
          napt_pkg::CMD_IN: begin
            ram_raddr = alu_sum[IDX_W-1:0];
            if (alu_sum < {{(ADDR_W-SZ_W){1'b0}}, n_eff}) begin
              state_nxt = napt_pkg::S_IN_RD;
            end else begin
              out_valid_nxt = 1'b1;
              out_rsp_nxt   = '{new_addr: '0, status: napt_pkg::ST_UNKNOWN};
              state_nxt     = napt_pkg::S_IDLE;
            end
          end
          napt_pkg::CMD_OUT: begin
            if (addr_r == '0) begin
              out_valid_nxt = 1'b1;
              out_rsp_nxt   = '{new_addr: '0, status: napt_pkg::ST_FULL};
              state_nxt     = napt_pkg::S_IDLE;
            end else begin
              state_nxt = napt_pkg::S_SCAN;
            end
          end
          napt_pkg::CMD_REL: begin
            if (addr_r == '0) begin
              out_valid_nxt = 1'b1;
              out_rsp_nxt   = '{new_addr: '0, status: napt_pkg::ST_NOT_FOUND};
              state_nxt     = napt_pkg::S_IDLE;
            end else begin
              state_nxt = napt_pkg::S_SCAN;
            end
          end
          default: begin
            out_valid_nxt = 1'b1;
            out_rsp_nxt   = '{new_addr: '0, status: napt_pkg::ST_UNKNOWN};
            state_nxt     = napt_pkg::S_IDLE;
          end
        endcase
      end

      // Inbound: slot data is back from the RAM
      napt_pkg::S_IN_RD: begin
        out_valid_nxt = 1'b1;
        state_nxt     = napt_pkg::S_IDLE;
        if (!alu_flags.free) begin
          out_rsp_nxt = '{new_addr: ram_rdata, status: napt_pkg::ST_OK};
        end else begin
          out_rsp_nxt = '{new_addr: '0, status: napt_pkg::ST_UNKNOWN};
        end
      end

      // One slot read issued and one compared per cycle
      napt_pkg::S_SCAN: begin
        pend_nxt = issue;
        cidx_nxt = idx_r[IDX_W-1:0];
        if (issue) begin
          idx_nxt = idx_r + SZ_W'(1);
        end
        if (pend_r && alu_flags.match) begin
          if (cmd_r == napt_pkg::CMD_OUT) begin
            slot_nxt  = cidx_r;
            state_nxt = napt_pkg::S_FIN;
          end else begin
            ram_we        = 1'b1;
            ram_waddr     = cidx_r;
            ram_wdata     = '0;
            used_nxt      = (used_r != '0) ? used_r - USED_W'(1) : used_r;
            out_valid_nxt = 1'b1;
            out_rsp_nxt   = '{new_addr: '0, status: napt_pkg::ST_RELEASED};
            state_nxt     = napt_pkg::S_IDLE;
          end
        end else begin
          // remember the lowest free slot for a later bind
          if (pend_r && alu_flags.free && !hfree_r) begin
            hfree_nxt = 1'b1;
            free_nxt  = cidx_r;
          end
          if (!pend_r && !issue) begin
            if (cmd_r == napt_pkg::CMD_OUT && hfree_r) begin
              ram_we    = 1'b1;
              ram_waddr = free_r;
              ram_wdata = addr_r;
              used_nxt  = (used_r != napt_pkg::COUNT_MAX) ? used_r + USED_W'(1) : used_r;
              slot_nxt  = free_r;
              state_nxt = napt_pkg::S_FIN;
            end else begin
              out_valid_nxt = 1'b1;
              out_rsp_nxt   = '{new_addr: '0,
                                status: (cmd_r == napt_pkg::CMD_OUT) ?
                                        napt_pkg::ST_FULL : napt_pkg::ST_NOT_FOUND};
              state_nxt     = napt_pkg::S_IDLE;
            end
          end
        end
      end

      // Public address = pool_base + slot
      napt_pkg::S_FIN: begin
        alu_op        = napt_pkg::ALU_ADD;
        out_valid_nxt = 1'b1;
        out_rsp_nxt   = '{new_addr: alu_sum, status: napt_pkg::ST_OK};
        state_nxt     = napt_pkg::S_IDLE;
      end

      default: begin
        state_nxt = napt_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/nat_address_pool_translator_unit.sv
// Top level of the NAT address pool translator: configuration registers,
// binding table RAM, shared unit and sequencer. Depends on napt_pkg,
// napt_ram, napt_alu and napt_ctrl.
//
//   channel  | ports                         | handshake
//   ---------+-------------------------------+-----------------------------
//   request  | start, busy, in_req           | taken when start && !busy
//   result   | out_valid, out_rsp            | one-cycle strobe, no stall
//   config   | cfg_we, cfg_idx, cfg_wdata    | written when cfg_we is high
//
// Inbound: the request passes S_DISP, which issues the slot read, and S_IN_RD
// before the registered result strobe. Outbound and release requests scan
// n = min(pool_size, POOL_DEPTH) slots one by one through the single RAM read port.
// After reset a clearing pass zeroes all POOL_DEPTH table slots; busy is
// high meanwhile and configuration writes are still taken.
// The receiver cannot stall; each result is shown for one cycle only.
module nat_address_pool_translator_unit #(
  parameter int POOL_DEPTH = napt_pkg::POOL_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  napt_pkg::req_t                   in_req,
  output logic                             out_valid,
  output napt_pkg::rsp_t                   out_rsp,
  input  logic                             cfg_we,
  input  logic [napt_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [napt_pkg::ADDR_W-1:0]      cfg_wdata
);

  localparam int IDX_W  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int ADDR_W = napt_pkg::ADDR_W;

  logic [ADDR_W-1:0]           pool_base_r;
  logic [napt_pkg::SIZE_W-1:0] pool_size_r;

  logic                        ram_we;
  logic [IDX_W-1:0]            ram_waddr;
  logic [ADDR_W-1:0]           ram_wdata;
  logic [IDX_W-1:0]            ram_raddr;
  logic [ADDR_W-1:0]           ram_rdata;

  napt_pkg::alu_op_e           alu_op;
  logic [ADDR_W-1:0]           alu_key;
  logic [ADDR_W-1:0]           alu_slot;
  logic [ADDR_W-1:0]           alu_sum;
  napt_pkg::alu_flags_t        alu_flags;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r <= '0;
      pool_size_r <= '0;
    end else if (cfg_we) begin
      if (cfg_idx == napt_pkg::CFG_POOL_BASE) begin
        pool_base_r <= cfg_wdata;
      end else if (cfg_idx == napt_pkg::CFG_POOL_SIZE) begin
        pool_size_r <= cfg_wdata[napt_pkg::SIZE_W-1:0];
      end
    end
  end

  // Binding table
  napt_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (POOL_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  napt_alu u_alu (
    .op      (alu_op),
    .key     (alu_key),
    .base    (pool_base_r),
    .slot    (alu_slot),
    .rd_data (ram_rdata),
    .sum     (alu_sum),
    .flags   (alu_flags)
  );

  napt_ctrl #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp),
    .pool_size (pool_size_r),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .alu_op    (alu_op),
    .alu_key   (alu_key),
    .alu_slot  (alu_slot),
    .alu_sum   (alu_sum),
    .alu_flags (alu_flags)
  );

endmodule

### rtl/core/napt_chk.sv
// Port-level checker for the NAT address pool translator, bound to the top.
// Depends on napt_pkg and nat_address_pool_translator_unit_assert.svh.
`include "nat_address_pool_translator_unit_assert.svh"

module napt_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input logic           out_valid,
  input napt_pkg::rsp_t out_rsp
);

  // An accepted request keeps the block busy until its result
  `NAPT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "request accepted but block not busy")

  // Result strobe is a single cycle and returns the block to idle
  `NAPT_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid, "result strobe held two cycles")
  `NAPT_ASSERT_NOW(a_strobe_idle, out_valid, !busy, "result shown while still busy")

  // Status code range and zero address on failure
  `NAPT_ASSERT_NOW(a_status_code, out_valid,
    out_rsp.status == napt_pkg::ST_OK || out_rsp.status == napt_pkg::ST_UNKNOWN ||
    out_rsp.status == napt_pkg::ST_FULL || out_rsp.status == napt_pkg::ST_RELEASED ||
    out_rsp.status == napt_pkg::ST_NOT_FOUND, "status code out of range")
  `NAPT_ASSERT_NOW(a_fail_zero, out_valid && out_rsp.status != napt_pkg::ST_OK,
    out_rsp.new_addr == '0, "nonzero address on a failed request")

endmodule

bind nat_address_pool_translator_unit napt_chk u_napt_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_rsp   (out_rsp)
);

### tb/napt_result_checker.sv
// Result checker for the NAT address pool translator: tracks config writes,
// predicts each accepted request from its own pool table and compares results.
// Depends on napt_pkg.
`timescale 1ns / 100ps

module napt_result_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  napt_pkg::req_t                 in_req,
  input  logic                           out_valid,
  input  napt_pkg::rsp_t                 out_rsp,
  input  logic                           cfg_we,
  input  logic [napt_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [napt_pkg::ADDR_W-1:0]    cfg_wdata,
  output int                             err_count,
  output int                             pending_cnt
);

  localparam int ADDR_W    = napt_pkg::ADDR_W;
  localparam int USED_W    = napt_pkg::SIZE_W;
  localparam int TBL_IW    = $clog2(napt_pkg::POOL_DEPTH_DEF);
  localparam int EXP_DEPTH = 4;

  // Shadow of the block's pool table and registers
  logic [ADDR_W-1:0]           bind_tbl [napt_pkg::POOL_DEPTH_DEF];
  logic [ADDR_W-1:0]           base_q;
  logic [napt_pkg::SIZE_W-1:0] size_q;
  logic [napt_pkg::SIZE_W-1:0] used_q;

  // Expected results in request order
  napt_pkg::rsp_t              exp_fifo [EXP_DEPTH];
  logic [1:0]                  exp_wr_q;
  logic [1:0]                  exp_rd_q;
  int                          exp_cnt;

  // Lowest slot among the first n that holds v, or -1
  function automatic int first_slot(input logic [ADDR_W-1:0] v, input int n);
    for (int i = 0; i < n; i++)
      if (bind_tbl[i] == v) return i;
    return -1;
  endfunction

  // Apply one request to the shadow table and return the result it gives
  function automatic napt_pkg::rsp_t predict_translation(input napt_pkg::req_t r);
    napt_pkg::rsp_t    o;
    int                n;
    int                slot;
    logic [ADDR_W-1:0] off;
    n = (size_q > napt_pkg::POOL_DEPTH_DEF) ? napt_pkg::POOL_DEPTH_DEF : int'(size_q);
    o.new_addr = '0;
    o.status   = napt_pkg::ST_UNKNOWN;
    case (napt_pkg::cmd_e'(r.cmd))
      napt_pkg::CMD_IN: begin
        off = r.addr - base_q;
        if (off < n) begin
          if (bind_tbl[off[TBL_IW-1:0]] != '0) begin
            o.new_addr = bind_tbl[off[TBL_IW-1:0]];
            o.status   = napt_pkg::ST_OK;
          end
        end
      end
      napt_pkg::CMD_OUT: begin
        o.status = napt_pkg::ST_FULL;
        if (r.addr != '0) begin
          slot = first_slot(r.addr, n);
          // no binding yet: take the lowest free slot
          if (slot < 0) begin
            slot = first_slot('0, n);
            if (slot >= 0) begin
              bind_tbl[slot] = r.addr;
              if (used_q < napt_pkg::COUNT_MAX) used_q = used_q + USED_W'(1);
            end
          end
          if (slot >= 0) begin
            o.new_addr = base_q + ADDR_W'(slot);
            o.status   = napt_pkg::ST_OK;
          end
        end
      end
      napt_pkg::CMD_REL: begin
        o.status = napt_pkg::ST_NOT_FOUND;
        if (r.addr != '0) begin
          slot = first_slot(r.addr, n);
          if (slot >= 0) begin
            bind_tbl[slot] = '0;
            if (used_q > 0) used_q = used_q - USED_W'(1);
            o.status = napt_pkg::ST_RELEASED;
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  always @(posedge clk) begin
    napt_pkg::rsp_t exp_rsp;
    if (!rst_n) begin
      for (int i = 0; i < napt_pkg::POOL_DEPTH_DEF; i++) bind_tbl[i] = '0;
      base_q   = '0;
      size_q   = '0;
      used_q   = '0;
      exp_wr_q = '0;
      exp_rd_q = '0;
      exp_cnt  = 0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (napt_pkg::cfg_reg_e'(cfg_idx))
          napt_pkg::CFG_POOL_BASE: base_q = cfg_wdata;
          napt_pkg::CFG_POOL_SIZE: size_q = cfg_wdata[napt_pkg::SIZE_W-1:0];
          default: ;
        endcase
      end
      // result check comes first: it belongs to an earlier request
      if (out_valid) begin
        if (exp_cnt == 0) begin
          $error("out_rsp: result with no request pending (new_addr %h status %0d)",
                 out_rsp.new_addr, out_rsp.status);
          err_count++;
        end else begin
          exp_rsp  = exp_fifo[exp_rd_q];
          exp_rd_q = exp_rd_q + 2'd1;
          exp_cnt--;
          if (out_rsp.new_addr !== exp_rsp.new_addr) begin
            $error("new_addr: expected %h, actual %h", exp_rsp.new_addr, out_rsp.new_addr);
            err_count++;
          end
          if (out_rsp.status !== exp_rsp.status) begin
            $error("status: expected %0d, actual %0d", exp_rsp.status, out_rsp.status);
            err_count++;
          end
        end
      end
      // new request: store its predicted result
      if (start && !busy) begin
        if (exp_cnt == EXP_DEPTH) begin
          $error("in_req: too many requests pending (%0d)", exp_cnt);
          err_count++;
        end else begin
          exp_fifo[exp_wr_q] = predict_translation(in_req);
          exp_wr_q = exp_wr_q + 2'd1;
          exp_cnt++;
        end
      end
    end
    pending_cnt = exp_cnt;
  end

endmodule

### tb/nat_address_pool_translator_unit_tb.sv
// Testbench top for the NAT address pool translator: clock, reset, request
// and config stimulus, watchdog and verdict. Depends on napt_pkg,
// napt_result_checker and the nat_address_pool_translator_unit RTL.
`timescale 1ns / 100ps

module nat_address_pool_translator_unit_tb;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 270;  // longest scan plus margin
  localparam int POOL_ADDRS     = 40;
  localparam int ADDR_W         = napt_pkg::ADDR_W;
  localparam int SIZE_W         = napt_pkg::SIZE_W;

  logic                           clk;
  logic                           rst_n;
  logic                           start;
  logic                           busy;
  napt_pkg::req_t                 in_req;
  logic                           out_valid;
  napt_pkg::rsp_t                 out_rsp;
  logic                           cfg_we;
  logic [napt_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [ADDR_W-1:0]              cfg_wdata;
  int                             err_count;
  int                             pending_cnt;
  int                             stall_cycles;

  // Stimulus state
  bit                             no_gaps;
  logic [ADDR_W-1:0]              cur_base;
  logic [SIZE_W-1:0]              cur_size;
  logic [ADDR_W-1:0]              host_addrs [POOL_ADDRS];

  nat_address_pool_translator_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  napt_result_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_req      (in_req),
    .out_valid   (out_valid),
    .out_rsp     (out_rsp),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .err_count   (err_count),
    .pending_cnt (pending_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: cycles with no request, result or register write
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Present one request and hold it until the block is not busy; random gaps ahead of it
  task automatic issue(input napt_pkg::cmd_e c, input logic [ADDR_W-1:0] a);
    napt_pkg::req_t r;
    r.cmd  = c;
    r.addr = a;
    if (!no_gaps) begin
      while ($urandom_range(99) < 29) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start  <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Stop requesting and wait until every result is back and the block is idle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0 || busy) @(posedge clk);
  endtask

  task automatic set_pool(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] size);
    cfg_we    <= 1'b1;
    cfg_idx   <= napt_pkg::CFG_POOL_BASE;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_idx   <= napt_pkg::CFG_POOL_SIZE;
    cfg_wdata <= size;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_base  = base;
    cur_size  = size[SIZE_W-1:0];
  endtask

  // Mostly hosts from a small set so bindings get reused, filled and released
  task automatic random_request();
    int                n;
    int                pick;
    napt_pkg::cmd_e    c;
    logic [ADDR_W-1:0] a;
    n = (cur_size > napt_pkg::POOL_DEPTH_DEF) ? napt_pkg::POOL_DEPTH_DEF : int'(cur_size);
    pick = $urandom_range(99);
    if (pick < 30)      c = napt_pkg::CMD_IN;
    else if (pick < 70) c = napt_pkg::CMD_OUT;
    else if (pick < 95) c = napt_pkg::CMD_REL;
    else                c = napt_pkg::CMD_RSV;
    pick = $urandom_range(99);
    if (c == napt_pkg::CMD_IN && pick < 80) a = cur_base + $urandom_range(n + 1);
    else if (pick < 85)           a = host_addrs[$urandom_range(POOL_ADDRS - 1)];
    else if (pick < 90)           a = '0;
    else                          a = $urandom;
    issue(c, a);
  endtask

  task automatic run_phase(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] size,
                           input int count, input int quiet);
    drain();
    set_pool(base, size);
    for (int k = 0; k < count; k++) begin
      no_gaps = (k < quiet);
      random_request();
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_req    = '0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    no_gaps   = 1'b0;
    cur_base  = '0;
    cur_size  = '0;
    for (int i = 0; i < POOL_ADDRS; i++) host_addrs[i] = $urandom | 32'h1;
    host_addrs[0] = 32'hFFFF_FFFF;
    host_addrs[1] = 32'h0000_0001;
    host_addrs[2] = 32'h8000_0000;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: pool of four wrapping past the top of the address space
    set_pool(32'hFFFF_FFFE, 32'd4);
    issue(napt_pkg::CMD_IN,  32'hFFFF_FFFE);  // free slot
    issue(napt_pkg::CMD_OUT, 32'h0A00_0001);  // slot 0
    issue(napt_pkg::CMD_OUT, 32'hC0A8_0001);  // slot 1
    issue(napt_pkg::CMD_OUT, 32'hFFFF_FFFF);  // slot 2, public address wraps to zero
    issue(napt_pkg::CMD_OUT, 32'h0A00_0001);  // existing binding
    issue(napt_pkg::CMD_IN,  32'h0000_0000);  // wrapped public address
    issue(napt_pkg::CMD_IN,  32'hFFFF_FFFD);  // just below the pool
    issue(napt_pkg::CMD_OUT, 32'h0000_0000);  // zero cannot be bound
    issue(napt_pkg::CMD_REL, 32'h0000_0000);  // zero cannot be released
    issue(napt_pkg::CMD_REL, 32'h0000_0001);  // not bound
    issue(napt_pkg::CMD_REL, 32'hC0A8_0001);  // frees slot 1
    issue(napt_pkg::CMD_OUT, 32'h0000_0001);  // reuses slot 1
    issue(napt_pkg::CMD_OUT, 32'h7FFF_FFFF);  // slot 3, pool now full
    issue(napt_pkg::CMD_OUT, 32'h8000_0000);  // pool full
    issue(napt_pkg::CMD_RSV, 32'hFFFF_FFFE);  // unused command
    issue(napt_pkg::CMD_IN,  32'h0000_0001);  // last slot
    // shrink: upper bindings stay but are hidden
    drain();
    set_pool(32'hFFFF_FFFE, 32'd2);
    issue(napt_pkg::CMD_REL, 32'hFFFF_FFFF);
    issue(napt_pkg::CMD_IN,  32'h0000_0000);
    issue(napt_pkg::CMD_OUT, 32'h8000_0000);
    // grow back: hidden bindings reappear
    drain();
    set_pool(32'hFFFF_FFFE, 32'd4);
    issue(napt_pkg::CMD_IN,  32'h0000_0000);
    issue(napt_pkg::CMD_REL, 32'h0A00_0001);
    issue(napt_pkg::CMD_OUT, 32'h8000_0000);

    // Random phases over several pool settings
    run_phase(32'h0000_0000, 32'd0,   40,  0);
    run_phase(32'hFFFF_FFF8, 32'd16,  300, 0);
    run_phase($urandom,      32'd1,   150, 0);
    run_phase($urandom,      32'd8,   400, 250);
    run_phase(32'hFFFF_FFFF, 32'd511, 120, 0);
    run_phase($urandom,      32'd256, 80,  0);
    run_phase($urandom,      32'd5,   300, 0);
    run_phase(32'h0A00_0000, 32'd12,  260, 0);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0 && pending_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
